// ===== hdl/pairing_handshake_tracker_core_assert.svh =====
// assertion macros for the pairing handshake tracker
`ifndef PAIRING_HANDSHAKE_TRACKER_CORE_ASSERT_SVH
`define PAIRING_HANDSHAKE_TRACKER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define PHT_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pht assertion failed");
// next-cycle implication
`define PHT_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pht assertion failed");
`else
`define PHT_ASSERT_IMP(name, clk, rst, ante, cons)
`define PHT_ASSERT_NXT(name, clk, rst, ante, cons)
`endif

`endif

// ===== hdl/pht_pkg.sv =====
// types, codes and phase priority function for the pairing handshake tracker
package pht_pkg;

   typedef enum logic [3:0] {
      ACT_BEGIN       = 4'd0,
      ACT_RESET       = 4'd1,
      ACT_HELLO_TX    = 4'd2,
      ACT_HELLO_RX    = 4'd3,
      ACT_LOC_DEC     = 4'd4,
      ACT_REM_DEC     = 4'd5,
      ACT_LOC_PREP    = 4'd6,
      ACT_REM_PREP    = 4'd7,
      ACT_LOC_COMMIT  = 4'd8,
      ACT_REM_COMMIT  = 4'd9,
      ACT_COMPLETE    = 4'd10,
      ACT_FAIL        = 4'd11,
      ACT_MATCH       = 4'd12
   } action_type;

   typedef enum logic [2:0] {
      PH_INACTIVE   = 3'd0,
      PH_HELLO      = 3'd1,
      PH_AWAIT      = 3'd2,
      PH_PREPARING  = 3'd3,
      PH_COMMITTING = 3'd4,
      PH_COMPLETED  = 3'd5,
      PH_FAILED     = 3'd6
   } phase_type;

   // progress flag positions, flag k belongs to action k+2
   localparam int PG_HELLO_TX   = 0;
   localparam int PG_HELLO_RX   = 1;
   localparam int PG_LOC_DEC    = 2;
   localparam int PG_REM_DEC    = 3;
   localparam int PG_LOC_PREP   = 4;
   localparam int PG_REM_PREP   = 5;
   localparam int PG_LOC_COMMIT = 6;
   localparam int PG_REM_COMMIT = 7;

   localparam int PROG_W  = 8;
   localparam int ID_W    = 64;
   localparam int GEN_W   = 64;
   localparam int SCOPE_W = 16;

   typedef struct packed {
      phase_type           phase;
      logic [PROG_W-1:0]   progress;
      logic [ID_W-1:0]     id_high;
      logic [ID_W-1:0]     id_low;
      logic [GEN_W-1:0]    generation;
      logic [SCOPE_W-1:0]  local_perm;
      logic [SCOPE_W-1:0]  remote_perm;
   } track_state_type;

   typedef struct packed {
      action_type          action;
      logic [ID_W-1:0]     id_high;
      logic [ID_W-1:0]     id_low;
      logic [GEN_W-1:0]    generation;
      logic [SCOPE_W-1:0]  permissions;
   } event_type;

   // phase from progress flags, highest priority first
   function automatic phase_type phase_of(input logic [PROG_W-1:0] p);
      phase_type ph;
      if ((p[PG_LOC_COMMIT] && p[PG_REM_COMMIT]) || (p[PG_LOC_PREP] && p[PG_REM_PREP])
          || p[PG_LOC_COMMIT]) begin
         ph = PH_COMMITTING;
      end else if ((p[PG_LOC_DEC] && p[PG_REM_DEC]) || p[PG_LOC_PREP]) begin
         ph = PH_PREPARING;
      end else if (p[PG_HELLO_TX] && p[PG_HELLO_RX]) begin
         ph = PH_AWAIT;
      end else begin
         ph = PH_HELLO;
      end
      return ph;
   endfunction

endpackage

// ===== hdl/pht_eval.sv =====
// next-state and acceptance logic for one tracker event
module pht_eval #(
   parameter int PERM_WIDTH = 16
) (
   input  pht_pkg::track_state_type cur,
   input  pht_pkg::event_type       evt,
   output pht_pkg::track_state_type nxt,
   output logic                     ok
);

   logic [pht_pkg::SCOPE_W-1:0] perm_m;
   logic [pht_pkg::PROG_W-1:0]  mark_prog;
   logic [2:0]                  flag_idx;
   logic [3:0]                  act_raw;
   logic                        active;
   logic                        can_mark;
   logic                        both_dec;
   logic                        both_prep;
   logic                        both_commit;
   pht_pkg::phase_type          mark_phase;
   pht_pkg::track_state_type    cleared;

   // permission bits at index PERM_WIDTH and above are dropped
   always_comb begin
      for (int i = 0; i < pht_pkg::SCOPE_W; i++) begin
         perm_m[i] = (i < PERM_WIDTH) ? evt.permissions[i] : 1'b0;
      end
   end

   always_comb begin
      act_raw     = evt.action;
      flag_idx    = 3'(act_raw - 4'd2);
      active      = (cur.phase == pht_pkg::PH_HELLO) || (cur.phase == pht_pkg::PH_AWAIT)
                 || (cur.phase == pht_pkg::PH_PREPARING)
                 || (cur.phase == pht_pkg::PH_COMMITTING);
      can_mark    = active && !cur.progress[flag_idx];
      mark_prog   = cur.progress | (pht_pkg::PROG_W'(1) << flag_idx);
      mark_phase  = pht_pkg::phase_of(mark_prog);
      both_dec    = cur.progress[pht_pkg::PG_LOC_DEC] && cur.progress[pht_pkg::PG_REM_DEC];
      both_prep   = cur.progress[pht_pkg::PG_LOC_PREP] && cur.progress[pht_pkg::PG_REM_PREP];
      both_commit = cur.progress[pht_pkg::PG_LOC_COMMIT]
                 && cur.progress[pht_pkg::PG_REM_COMMIT];
      cleared       = '0;
      cleared.phase = pht_pkg::PH_INACTIVE;
   end

   always_comb begin
      nxt = cur;
      ok  = 1'b0;
      case (evt.action)
         pht_pkg::ACT_BEGIN: begin
            nxt = cleared;
            if (((evt.id_high == '0) && (evt.id_low == '0)) || (evt.generation == '0)) begin
               nxt.phase = pht_pkg::PH_FAILED;
            end else begin
               nxt.id_high    = evt.id_high;
               nxt.id_low     = evt.id_low;
               nxt.generation = evt.generation;
               nxt.phase      = pht_pkg::PH_HELLO;
               ok             = 1'b1;
            end
         end
         pht_pkg::ACT_RESET: begin
            nxt = cleared;
         end
         pht_pkg::ACT_HELLO_TX, pht_pkg::ACT_HELLO_RX: begin
            if (can_mark) begin
               nxt.progress = mark_prog;
               nxt.phase    = mark_phase;
               ok           = 1'b1;
            end
         end
         pht_pkg::ACT_LOC_DEC: begin
            // scopes are stored while the flag is clear, even when an inactive phase refuses the mark
            if (!cur.progress[pht_pkg::PG_LOC_DEC]) begin
               nxt.local_perm = perm_m;
               if (active) begin
                  nxt.progress = mark_prog;
                  nxt.phase    = mark_phase;
                  ok           = 1'b1;
               end
            end
         end
         pht_pkg::ACT_REM_DEC: begin
            if (!cur.progress[pht_pkg::PG_REM_DEC]) begin
               nxt.remote_perm = perm_m;
               if (active) begin
                  nxt.progress = mark_prog;
                  nxt.phase    = mark_phase;
                  ok           = 1'b1;
               end
            end
         end
         pht_pkg::ACT_LOC_PREP, pht_pkg::ACT_REM_PREP: begin
            if (both_dec && can_mark) begin
               nxt.progress = mark_prog;
               nxt.phase    = mark_phase;
               ok           = 1'b1;
            end
         end
         pht_pkg::ACT_LOC_COMMIT, pht_pkg::ACT_REM_COMMIT: begin
            if (both_prep && can_mark) begin
               nxt.progress = mark_prog;
               nxt.phase    = mark_phase;
               ok           = 1'b1;
            end
         end
         pht_pkg::ACT_COMPLETE: begin
            if (both_commit && (cur.phase != pht_pkg::PH_COMPLETED)) begin
               nxt.phase = pht_pkg::PH_COMPLETED;
               ok        = 1'b1;
            end
         end
         pht_pkg::ACT_FAIL: begin
            if (cur.phase != pht_pkg::PH_COMPLETED) begin
               nxt.phase = pht_pkg::PH_FAILED;
               ok        = 1'b1;
            end
         end
         pht_pkg::ACT_MATCH: begin
            ok = (cur.phase != pht_pkg::PH_INACTIVE) && (cur.phase != pht_pkg::PH_FAILED)
              && (evt.id_high == cur.id_high) && (evt.id_low == cur.id_low)
              && (evt.generation == cur.generation);
         end
         default: begin
            // unused codes leave everything alone
            nxt = cur;
         end
      endcase
   end

endmodule

// ===== hdl/pairing_handshake_tracker_core.sv =====
// pairing handshake tracker top level: input register, event logic, response register
// a req transaction passes the input register, then the update loads the response register
// throughput: one transaction per cycle while the rsp side is not stalled
// the tracker state and the response only advance together, so a stalled rsp holds both
// reset clears both valid flags and the tracker state (phase inactive, flags and scopes zero)
`include "pairing_handshake_tracker_core_assert.svh"

module pairing_handshake_tracker_core #(
   parameter int PERM_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_action,
   input  logic [63:0] req_request_id_high,
   input  logic [63:0] req_request_id_low,
   input  logic [63:0] req_generation,
   input  logic [15:0] req_permissions,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_accepted,
   output logic [2:0]  rsp_txn_state,
   output logic [7:0]  rsp_progress_bits,
   output logic [15:0] rsp_local_scopes,
   output logic [15:0] rsp_remote_scopes
);

   // input register: holds one transaction waiting for the tracker
   logic                     in_valid_ff;
   logic                     in_valid_in;
   pht_pkg::event_type       in_evt_ff;
   pht_pkg::event_type       in_evt_in;

   // tracker state, also the payload of the response
   pht_pkg::track_state_type state_ff;
   pht_pkg::track_state_type state_in;
   pht_pkg::track_state_type state_nxt;

   // response register
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic                     rsp_ok_ff;
   logic                     rsp_ok_in;
   logic                     eval_ok;

   logic                     advance;
   logic                     take_req;
   logic                     keep_flags;
   logic                     flags_kept;
   logic                     active_phase;
   logic                     commit_any;
   logic                     prep_both;

   // the event moves forward when the response slot is empty or being drained
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign take_req  = req_valid && req_ready;

   pht_eval #(
      .PERM_WIDTH (PERM_WIDTH)
   ) u_eval (
      .cur (state_ff),
      .evt (in_evt_ff),
      .nxt (state_nxt),
      .ok  (eval_ok)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_evt_in   = in_evt_ff;
      if (take_req) begin
         in_valid_in           = 1'b1;
         in_evt_in.action      = pht_pkg::action_type'(req_action);
         in_evt_in.id_high     = req_request_id_high;
         in_evt_in.id_low      = req_request_id_low;
         in_evt_in.generation  = req_generation;
         in_evt_in.permissions = req_permissions;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         // tracker update and response load happen in the same cycle
         state_in     = state_nxt;
         rsp_ok_in    = eval_ok;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and tracker state, all-zero state is phase inactive
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         state_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      in_evt_ff <= in_evt_in;
      rsp_ok_ff <= rsp_ok_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = rsp_ok_ff;
   assign rsp_txn_state     = state_ff.phase;
   assign rsp_progress_bits = state_ff.progress;
   assign rsp_local_scopes  = state_ff.local_perm;
   assign rsp_remote_scopes = state_ff.remote_perm;

   // helpers for the checks below
   assign keep_flags   = advance && (in_evt_ff.action != pht_pkg::ACT_BEGIN)
                      && (in_evt_ff.action != pht_pkg::ACT_RESET);
   assign flags_kept   = &(state_nxt.progress | ~state_ff.progress);
   assign active_phase = (state_ff.phase == pht_pkg::PH_HELLO)
                      || (state_ff.phase == pht_pkg::PH_AWAIT)
                      || (state_ff.phase == pht_pkg::PH_PREPARING)
                      || (state_ff.phase == pht_pkg::PH_COMMITTING);
   assign commit_any   = state_ff.progress[pht_pkg::PG_LOC_COMMIT]
                      || state_ff.progress[pht_pkg::PG_REM_COMMIT];
   assign prep_both    = state_ff.progress[pht_pkg::PG_LOC_PREP]
                      && state_ff.progress[pht_pkg::PG_REM_PREP];

   // progress flags are only ever cleared by begin or reset
   `PHT_ASSERT_IMP(a_flags_grow, clock, reset, keep_flags, flags_kept)
   // a processed event always leaves a response behind
   `PHT_ASSERT_NXT(a_rsp_loaded, clock, reset, advance, rsp_valid_ff)
   // a commit flag cannot exist without both prepare flags
   `PHT_ASSERT_IMP(a_commit_order, clock, reset, commit_any, prep_both)
   // an active transaction was started with a valid generation
   `PHT_ASSERT_IMP(a_active_gen, clock, reset, active_phase, state_ff.generation != '0)

endmodule
